// ----- design/pli_pkg.sv -----
// shared types, constants and sequencer states of the piecewise linear interpolator
package pli_pkg;

   localparam int MaxPointsDefault = 16;
   localparam int CoordWidth       = 16;
   localparam int IndexWidth       = 4;
   localparam int CountWidth       = 5;
   localparam int ProductWidth     = 2 * CoordWidth;
   localparam int QuotWidth        = CoordWidth;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK0,
      ST_CHKL,
      ST_SCAN,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                    start;
      logic [ProductWidth-1:0] numer;
      logic [CoordWidth-1:0]   denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic                 busy;
      logic [QuotWidth-1:0] quot;
   } div_rsp_type;

endpackage

// ----- design/pli_ifs.sv -----
// request and response channel interfaces of the piecewise linear interpolator
interface pli_req_if;
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic [pli_pkg::IndexWidth-1:0]    point_index;
   pli_pkg::coord_type                x_value;
   pli_pkg::coord_type                y_value;

   modport source (output valid, output cmd, output point_index, output x_value,
                   output y_value, input ready);
   modport sink   (input valid, input cmd, input point_index, input x_value,
                   input y_value, output ready);
endinterface

interface pli_rsp_if;
   logic               valid;
   logic               ready;
   pli_pkg::coord_type y_out;

   modport source (output valid, output y_out, input ready);
   modport sink   (input valid, input y_out, output ready);
endinterface

// ----- design/pli_ram.sv -----
// generic single write port ram with registered read
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pli_div.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit in 16 bits
module pli_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pli_pkg::div_req_type div_req,
   output pli_pkg::div_rsp_type div_rsp
);

   localparam int QW = pli_pkg::QuotWidth;
   localparam int CW = $clog2(QW);

   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] sh_ff, sh_in;
   logic [QW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [QW:0]   trial;
   logic [QW:0]   diff;
   logic          fits;
   logic          last_step;

   always_comb begin
      trial     = {rem_ff, sh_ff[QW-1]};
      diff      = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      last_step = busy_ff && (cnt_ff == CW'(QW - 1));

      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = last_step;

      if (div_req.start) begin
         // high half of the dividend is below the divisor, so it seeds the remainder
         rem_in  = div_req.numer[pli_pkg::ProductWidth-1:QW];
         sh_in   = div_req.numer[QW-1:0];
         den_in  = div_req.denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[QW-1:0] : trial[QW-1:0];
         sh_in   = {sh_ff[QW-2:0], fits};
         cnt_in  = cnt_ff + CW'(1);
         busy_in = !last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.busy = busy_ff;
   assign div_rsp.quot = sh_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider did not start");

endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// piecewise linear table interpolator: breakpoint table, segment search and serial divide
//
// req_if carries requests: cmd 0 loads breakpoint point_index with (x_value, y_value),
// cmd 1 queries y for x_value. rsp_if returns one y_out per query, nothing per load.
// csr_wr_en / csr_wr_data write point_count (breakpoints in use, 0 acts as 1, values
// above MAX_POINTS act as MAX_POINTS); write it only while no query is in flight.
// A load writes the ram. A query reads entry 0, then the last entry, then scans the
// table one entry per cycle through the breakpoint ram until it finds the segment.
// Below the first x the result is entry 0's y and at or above the last x it is the last
// entry's y; a hit goes on through ST_MUL, ST_START and the 16-step divider in ST_DIV.
// Each result leaves through ST_FIN, and the next request is taken back in ST_IDLE.
// req_if.ready is low while a query is at work. The result sits in an output register;
// a stalled receiver holds it there and the block waits before handing over the next.
// Reset is synchronous: it clears the sequencer, the divider and point_count to 1.
// Table entries hold nothing until loaded and are not cleared by reset.
module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = pli_pkg::MaxPointsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   pli_req_if.sink                          req_if,
   pli_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [pli_pkg::CountWidth-1:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = pli_pkg::CoordWidth;

   pli_pkg::state_type state_ff, state_in;

   logic [pli_pkg::CountWidth-1:0] count_ff, count_in;
   logic [AW-1:0]                  last_ff, last_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   pli_pkg::coord_type             x_ff, x_in;
   pli_pkg::coord_type             px_ff, px_in;
   pli_pkg::coord_type             py_ff, py_in;
   logic [CW-1:0]                  dx_ff, dx_in;
   logic [CW-1:0]                  den_ff, den_in;
   logic [CW-1:0]                  dym_ff, dym_in;
   logic                           neg_ff, neg_in;
   logic [pli_pkg::ProductWidth-1:0] prod_ff, prod_in;
   pli_pkg::coord_type             res_ff, res_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   pli_pkg::coord_type             y_out_ff, y_out_in;

   logic                           req_take;
   logic                           load_take;
   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   logic [2*CW-1:0]                ram_wdata;
   logic [AW-1:0]                  ram_raddr;
   logic [2*CW-1:0]                ram_rdata;
   pli_pkg::coord_type             rd_x;
   pli_pkg::coord_type             rd_y;
   logic [AW-1:0]                  last_idx;
   logic [CW:0]                    dx_wide;
   logic [CW:0]                    den_wide;
   logic [CW:0]                    dy_wide;
   logic [CW:0]                    dy_abs;
   logic [CW+1:0]                  sum_wide;
   pli_pkg::coord_type             sum_sat;

   pli_pkg::div_req_type           div_req;
   pli_pkg::div_rsp_type           div_rsp;

   pli_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pli_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready = (state_ff == pli_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign load_take    = req_take && (req_if.cmd == pli_pkg::CMD_LOAD);

   assign ram_we    = load_take && (int'(req_if.point_index) < MAX_POINTS);
   assign ram_waddr = AW'(req_if.point_index);
   assign ram_wdata = {req_if.x_value, req_if.y_value};

   assign rd_x = ram_rdata[2*CW-1:CW];
   assign rd_y = ram_rdata[CW-1:0];

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_comb begin
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (int'(count_ff) > MAX_POINTS) begin
         last_idx = AW'(MAX_POINTS - 1);
      end else begin
         last_idx = AW'(count_ff - pli_pkg::CountWidth'(1));
      end
   end

   // segment deltas, x1 = prev entry and x2 = entry just read
   always_comb begin
      dx_wide  = {x_ff[CW-1], x_ff} - {px_ff[CW-1], px_ff};
      den_wide = {rd_x[CW-1], rd_x} - {px_ff[CW-1], px_ff};
      dy_wide  = {rd_y[CW-1], rd_y} - {py_ff[CW-1], py_ff};
      dy_abs   = dy_wide[CW] ? (~dy_wide + (CW+1)'(1)) : dy_wide;
   end

   // y1 plus or minus quotient, then clamp to 16 bits
   always_comb begin
      if (neg_ff) begin
         sum_wide = {{2{py_ff[CW-1]}}, py_ff} - {2'b00, div_rsp.quot};
      end else begin
         sum_wide = {{2{py_ff[CW-1]}}, py_ff} + {2'b00, div_rsp.quot};
      end
      if (!sum_wide[CW+1] && (sum_wide[CW:CW-1] != 2'b00)) begin
         sum_sat = {1'b0, {(CW-1){1'b1}}};
      end else if (sum_wide[CW+1] && (sum_wide[CW:CW-1] != 2'b11)) begin
         sum_sat = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sum_sat = sum_wide[CW-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      x_in       = x_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      dx_in      = dx_ff;
      den_in     = den_ff;
      dym_in     = dym_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_if.ready;
      y_out_in   = y_out_ff;
      ram_raddr  = '0;
      div_req    = '{start: 1'b0, numer: prod_ff, denom: den_ff};

      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req_take && (req_if.cmd == pli_pkg::CMD_QUERY)) begin
               x_in     = req_if.x_value;
               last_in  = last_idx;
               state_in = pli_pkg::ST_CHK0;
            end
         end
         pli_pkg::ST_CHK0: begin
            ram_raddr = last_ff;
            px_in     = rd_x;
            py_in     = rd_y;
            res_in    = rd_y;
            if (x_ff < rd_x) begin
               state_in = pli_pkg::ST_FIN;
            end else begin
               state_in = pli_pkg::ST_CHKL;
            end
         end
         pli_pkg::ST_CHKL: begin
            ram_raddr = AW'(1);
            res_in    = rd_y;
            idx_in    = AW'(1);
            if (x_ff >= rd_x) begin
               state_in = pli_pkg::ST_FIN;
            end else begin
               state_in = pli_pkg::ST_SCAN;
            end
         end
         pli_pkg::ST_SCAN: begin
            // next entry is fetched speculatively while this one is compared
            ram_raddr = idx_ff + AW'(1);
            if (x_ff < rd_x) begin
               dx_in    = dx_wide[CW-1:0];
               den_in   = den_wide[CW-1:0];
               dym_in   = dy_abs[CW-1:0];
               neg_in   = dy_wide[CW];
               state_in = pli_pkg::ST_MUL;
            end else begin
               px_in  = rd_x;
               py_in  = rd_y;
               idx_in = idx_ff + AW'(1);
            end
         end
         pli_pkg::ST_MUL: begin
            prod_in  = dx_ff * dym_ff;
            state_in = pli_pkg::ST_START;
         end
         pli_pkg::ST_START: begin
            div_req.start = 1'b1;
            state_in      = pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               res_in   = sum_sat;
               state_in = pli_pkg::ST_FIN;
            end
         end
         pli_pkg::ST_FIN: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in = 1'b1;
               y_out_in   = res_ff;
               state_in   = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pli_pkg::ST_IDLE;
         count_ff   <= pli_pkg::CountWidth'(1);
         rsp_vld_ff <= 1'b0;
         last_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
         last_ff    <= last_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      dx_ff    <= dx_in;
      den_ff   <= den_in;
      dym_ff   <= dym_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      y_out_ff <= y_out_in;
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.y_out = y_out_ff;

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_if.cmd == pli_pkg::CMD_QUERY)) |=> (state_ff == pli_pkg::ST_CHK0))
      else $error("query request did not start the search");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pli_pkg::ST_DIV))
      else $error("divider finished outside the divide wait");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::ST_SCAN) |-> ((idx_ff <= last_ff) && (idx_ff != '0)))
      else $error("segment scan ran past the last breakpoint");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::ST_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while idle");

endmodule
